// ===== rtl/core/bdq_pkg.sv =====
package bdq_pkg;

    localparam int DATA_W   = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_REMOVE     = 2'd2,
        REQ_NOP        = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE  = 2'd0,
        FSM_CMP   = 2'd1,
        FSM_APPLY = 2'd2
    } fsm_t;

    typedef enum logic [2:0] {
        CELL_HOLD       = 3'd0,
        CELL_COMPARE    = 3'd1,
        CELL_SHIFT_BACK = 3'd2,
        CELL_LOAD_TAIL  = 3'd3,
        CELL_REMOVE     = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     live;
        logic     tail;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/bdq_cell.sv =====
module bdq_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bdq_pkg::cell_ctrl_t                 ctrl,
    input  logic signed [bdq_pkg::DATA_W-1:0]   key,
    input  logic signed [bdq_pkg::DATA_W-1:0]   left_data,
    input  logic signed [bdq_pkg::DATA_W-1:0]   right_data,
    input  logic                                found_in,
    output logic signed [bdq_pkg::DATA_W-1:0]   data,
    output logic                                found_out
);

    logic signed [bdq_pkg::DATA_W-1:0] data_reg;
    logic signed [bdq_pkg::DATA_W-1:0] data_next;
    logic                              hit_reg;
    logic                              hit_next;

    always_comb
    begin
        data_next = data_reg;
        hit_next  = hit_reg;
        unique case (ctrl.op)
            bdq_pkg::CELL_HOLD:
            begin
            end
            bdq_pkg::CELL_COMPARE:
            begin
                hit_next = ctrl.live && (data_reg == key);
            end
            bdq_pkg::CELL_SHIFT_BACK:
            begin
                data_next = left_data;
            end
            bdq_pkg::CELL_LOAD_TAIL:
            begin
                if (ctrl.tail)
                begin
                    data_next = key;
                end
            end
            bdq_pkg::CELL_REMOVE:
            begin
                // close the gap at and behind the first match
                if (found_in || hit_reg)
                begin
                    data_next = right_data;
                end
                hit_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign data      = data_reg;
    assign found_out = found_in || hit_reg;

endmodule

// ===== rtl/core/bounded_deque_remove_by_value_unit.sv =====
// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_ready  req_type, value
// result    out        out_valid/out_ready  status, count, empty_res
//
// A request passes a compare step, where every cell compares its entry with
// the value, then an apply step, where the first-match prefix ripples down
// the cell row and the row shifts or loads the tail. One request is in flight
// at a time; a new request is taken only when the block is idle again.
// Reset empties the deque; entry contents are not cleared.
// A result waiting on out_ready stalls the apply step, the row holds.
module bounded_deque_remove_by_value_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bdq_pkg::REQ_W-1:0]           req_type,
    input  logic signed [bdq_pkg::DATA_W-1:0]   value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bdq_pkg::STATUS_W-1:0]        status,
    output logic [bdq_pkg::COUNT_W-1:0]         count,
    output logic                                empty_res
);

    localparam int HW = $clog2(CAPACITY + 1);

    bdq_pkg::fsm_t                     state_reg;
    bdq_pkg::fsm_t                     state_next;
    bdq_pkg::req_t                     req_reg;
    logic signed [bdq_pkg::DATA_W-1:0] value_reg;
    logic [HW-1:0]                     held_reg;
    logic [HW-1:0]                     held_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    bdq_pkg::status_t                  status_reg;
    bdq_pkg::status_t                  status_next;
    logic [bdq_pkg::COUNT_W-1:0]       count_reg;
    logic [bdq_pkg::COUNT_W-1:0]       count_next;
    logic                              empty_reg;
    logic                              empty_next;

    bdq_pkg::cell_op_t                 cell_op;
    logic                              full;
    logic                              fire;
    logic                              accept;
    logic                              load_result;

    logic signed [bdq_pkg::DATA_W-1:0] cell_data [CAPACITY];
    logic                              found_chain [CAPACITY+1];

    assign full     = (held_reg == HW'(CAPACITY));
    assign fire     = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == bdq_pkg::FSM_IDLE);
    assign accept   = in_valid && in_ready;

    assign found_chain[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        bdq_pkg::cell_ctrl_t               ctrl;
        logic signed [bdq_pkg::DATA_W-1:0] left_data;
        logic signed [bdq_pkg::DATA_W-1:0] right_data;

        assign ctrl.op   = cell_op;
        assign ctrl.live = (held_reg > HW'(i));
        assign ctrl.tail = (held_reg == HW'(i));

        if (i == 0)
        begin : g_head
            assign left_data = value_reg;
        end
        else
        begin : g_body
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_inner
            assign right_data = cell_data[i+1];
        end

        bdq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .key        (value_reg),
            .left_data  (left_data),
            .right_data (right_data),
            .found_in   (found_chain[i]),
            .data       (cell_data[i]),
            .found_out  (found_chain[i+1])
        );
    end

    always_comb
    begin
        state_next  = state_reg;
        cell_op     = bdq_pkg::CELL_HOLD;
        held_next   = held_reg;
        status_next = bdq_pkg::STATUS_DONE;
        load_result = 1'b0;
        unique case (state_reg)
            bdq_pkg::FSM_IDLE:
            begin
                if (accept)
                begin
                    state_next = bdq_pkg::FSM_CMP;
                end
            end
            bdq_pkg::FSM_CMP:
            begin
                cell_op    = bdq_pkg::CELL_COMPARE;
                state_next = bdq_pkg::FSM_APPLY;
            end
            bdq_pkg::FSM_APPLY:
            begin
                if (fire)
                begin
                    load_result = 1'b1;
                    state_next  = bdq_pkg::FSM_IDLE;
                    unique case (req_reg)
                        bdq_pkg::REQ_PUSH_FRONT, bdq_pkg::REQ_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = bdq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                cell_op   = (req_reg == bdq_pkg::REQ_PUSH_FRONT) ?
                                            bdq_pkg::CELL_SHIFT_BACK :
                                            bdq_pkg::CELL_LOAD_TAIL;
                                held_next = held_reg + HW'(1);
                            end
                        end
                        bdq_pkg::REQ_REMOVE:
                        begin
                            cell_op = bdq_pkg::CELL_REMOVE;
                            if (found_chain[CAPACITY])
                            begin
                                held_next = held_reg - HW'(1);
                            end
                            else
                            begin
                                status_next = bdq_pkg::STATUS_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = bdq_pkg::FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (load_result)
        begin
            out_valid_next = 1'b1;
        end
        count_next = bdq_pkg::COUNT_W'(held_next);
        empty_next = (held_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdq_pkg::FSM_IDLE;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= bdq_pkg::req_t'(req_type);
            value_reg <= value;
        end
        if (load_result)
        begin
            status_reg <= status_next;
            count_reg  <= count_next;
            empty_reg  <= empty_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign count     = count_reg;
    assign empty_res = empty_reg;

endmodule

// ===== rtl/core/bdq_checker.sv =====
module bdq_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [bdq_pkg::STATUS_W-1:0]        status,
    input logic [bdq_pkg::COUNT_W-1:0]         count,
    input logic                                empty_res
);

    a_one_in_flight: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready
    ) else $error("request taken while another is in flight");

    a_result_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count)
    ) else $error("stalled result changed");

    a_empty_matches_count: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (empty_res == (count == '0))
    ) else $error("empty flag disagrees with count");

    a_status_legal: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == bdq_pkg::STATUS_DONE) || (status == bdq_pkg::STATUS_FULL)
                      || (status == bdq_pkg::STATUS_NOT_FOUND)
    ) else $error("unused status code");

endmodule

bind bounded_deque_remove_by_value_unit bdq_checker u_bdq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .count     (count),
    .empty_res (empty_res)
);
